@@ hw/rtl/strict_local_extremum_detector_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the strict local extremum detector
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef STRICT_LOCAL_EXTREMUM_DETECTOR_ASSERT_SVH
`define STRICT_LOCAL_EXTREMUM_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define SLED_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sled assertion failed");
// Consequent must hold in the cycle after the antecedent
`define SLED_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sled assertion failed");
`else
`define SLED_ASSERT_NOW(label, clk, rstn, ante, cons)
`define SLED_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ hw/rtl/sled_pkg.sv @@
// ----------------------------------------------------------------------------
// sled_pkg
// Shared constants and types of the strict local extremum detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sled_pkg;

    // Default geometry limits and pixel depth
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    // Configuration register file
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_FIND_MAXIMA  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic                  FIND_MAXIMA_RST  = 1'b1;
    localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

    // Result item fields
    localparam int PEAK_COL_W   = 10;
    localparam int PEAK_ROW_W   = 10;
    localparam int PEAK_VALUE_W = 8;
    localparam int OUT_FIELDS_W = PEAK_COL_W + PEAK_ROW_W + PEAK_VALUE_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Candidates evaluated per input item
    localparam int NUM_CAND = 4;
    localparam int CAND_IDX_W = 2;

    // Position flags of the item in the evaluation stage
    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic last_col;
        logic last_row;
    } pos_flags_t;

    typedef struct packed {
        logic [PEAK_VALUE_W-1:0] value;
        logic [PEAK_ROW_W-1:0]   row;
        logic [PEAK_COL_W-1:0]   col;
    } peak_t;

    typedef struct packed {
        logic  vld;
        peak_t peak;
    } cand_t;

endpackage

@@ hw/rtl/strict_local_extremum_detector.sv @@
// ----------------------------------------------------------------------------
// strict_local_extremum_detector
// 3x3 strict local maximum / minimum detector on a raster pixel stream.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | content
//  s_      | in        | s_tvalid/s_tready  | one pixel per item
//  m_      | out       | m_tvalid/m_tready  | one report per item, tlast ends run
//  cfg_    | in        | cfg_valid/cfg_ready| register index and value
//
//  One pixel is taken per cycle unless m_ stalls; an item that completes
//  more than one report (last column or last row) holds the input until they
//  are sent; the result register sends one report per cycle while m_tready is high.
//  A pixel is held in the input register and its reports in the result register.
//  Reset clears counters, window and queue; line stores are not cleared.
//  A stall on m_ backs up through the evaluation stage to s_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "strict_local_extremum_detector_assert.svh"

module strict_local_extremum_detector #(
    parameter int MAX_WIDTH  = sled_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sled_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = sled_pkg::PIXEL_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input pixels
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0] s_tdata,   // pixel
    // reports
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sled_pkg::OUT_DATA_W-1:0]      m_tdata,   // peak_col, peak_row, peak_value
    output logic                                 m_tlast,   // last_of_run
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sled_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sled_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import sled_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Configuration registers
    logic                  find_maxima_reg;
    logic [CFG_DATA_W-1:0] image_width_reg;
    logic [CFG_DATA_W-1:0] image_height_reg;

    // Scan position of the next pixel
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;
    logic [CW-1:0] col_last;
    logic [RW-1:0] row_last;
    logic          last_col;
    logic          last_row;
    pos_flags_t    flags_now;

    // Evaluation stage
    logic                  s1_valid_reg, s1_valid_next;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [RW-1:0]         s1_row_reg;
    pos_flags_t            s1_flags_reg;

    logic [2*PIXEL_BITS-1:0] ls_rd_data;
    logic [2*PIXEL_BITS-1:0] ls_wr_data;
    logic [PIXEL_BITS-1:0]   above1;
    logic [PIXEL_BITS-1:0]   above2;
    cand_t                   cand [NUM_CAND];
    logic                    q_ready;
    logic                    s_fire;
    logic                    s1_fire;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            find_maxima_reg  <= FIND_MAXIMA_RST;
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FIND_MAXIMA:  find_maxima_reg  <= cfg_data[0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped last column and row
    always_comb begin
        if (image_width_reg == '0) begin
            col_last = '0;
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            col_last = CW'(MAX_WIDTH - 1);
        end else begin
            col_last = CW'(image_width_reg - 1'b1);
        end
        if (image_height_reg == '0) begin
            row_last = '0;
        end else if (32'(image_height_reg) > MAX_HEIGHT) begin
            row_last = RW'(MAX_HEIGHT - 1);
        end else begin
            row_last = RW'(image_height_reg - 1'b1);
        end
    end

    assign last_col = (col_cnt_reg >= col_last);
    assign last_row = (row_cnt_reg >= row_last);

    assign flags_now.row_ge1  = (row_cnt_reg != '0);
    assign flags_now.row_ge2  = (32'(row_cnt_reg) >= 2);
    assign flags_now.col_ge1  = (col_cnt_reg != '0);
    assign flags_now.col_ge2  = (32'(col_cnt_reg) >= 2);
    assign flags_now.last_col = last_col;
    assign flags_now.last_row = last_row;

    // Handshakes
    assign s1_fire  = s1_valid_reg && q_ready;
    assign s_tready = !s1_valid_reg || q_ready;
    assign s_fire   = s_tvalid && s_tready;

    // Scan counters
    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (s_fire) begin
            if (last_col) begin
                col_cnt_next = '0;
                row_cnt_next = last_row ? '0 : row_cnt_reg + 1'b1;
            end else begin
                col_cnt_next = col_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Input register
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_pixel_reg <= s_tdata[PIXEL_BITS-1:0];
            s1_col_reg   <= col_cnt_reg;
            s1_row_reg   <= row_cnt_reg;
            s1_flags_reg <= flags_now;
        end
    end

    // Both line stores share one address: low half previous row, high half the one above
    assign above1     = ls_rd_data[PIXEL_BITS-1:0];
    assign above2     = ls_rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
    assign ls_wr_data = {above1, s1_pixel_reg};

    sled_line_store #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (2 * PIXEL_BITS)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (ls_wr_data),
        .rd_en   (s_fire),
        .rd_addr (col_cnt_reg),
        .rd_data (ls_rd_data)
    );

    sled_nms #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_nms (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (s1_fire),
        .find_maxima (find_maxima_reg),
        .pixel       (s1_pixel_reg),
        .above1      (above1),
        .above2      (above2),
        .col         (s1_col_reg),
        .row         (s1_row_reg),
        .flags       (s1_flags_reg),
        .cand        (cand)
    );

    sled_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (s1_fire),
        .cand       (cand),
        .load_ready (q_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // Checks
    `SLED_ASSERT_NEXT(a_col_wrap, aclk, aresetn, s_fire && last_col, col_cnt_reg == '0)
    `SLED_ASSERT_NEXT(a_row_step, aclk, aresetn, s_fire && last_col && !last_row,
                      row_cnt_reg == $past(row_cnt_reg) + 1'b1)
    `SLED_ASSERT_NEXT(a_run_continues, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid)
    `SLED_ASSERT_NOW(a_col_range, aclk, aresetn, 1'b1, 32'(col_cnt_reg) < MAX_WIDTH)

endmodule

@@ hw/rtl/sled_line_store.sv @@
// ----------------------------------------------------------------------------
// sled_line_store
// Single-port-write, single-port-read line memory with registered read data
// and write-to-read bypass for a read of the address written in that cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sled_line_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [WIDTH-1:0] byp_data_reg;
    logic             byp_sel_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, new data wins on a same-address collision
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            byp_data_reg <= wr_data;
            byp_sel_reg  <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_sel_reg ? byp_data_reg : rd_data_reg;

endmodule

@@ hw/rtl/sled_nms.sv @@
// ----------------------------------------------------------------------------
// sled_nms
// 3x3 window registers and the strict extremum comparisons for the four
// candidate pixels that one input item can complete.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sled_nms #(
    parameter int MAX_WIDTH  = sled_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sled_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = sled_pkg::PIXEL_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          advance,
    input  logic                                          find_maxima,
    input  logic [PIXEL_BITS-1:0]                         pixel,
    input  logic [PIXEL_BITS-1:0]                         above1,
    input  logic [PIXEL_BITS-1:0]                         above2,
    input  logic [$clog2(MAX_WIDTH)-1:0]                  col,
    input  logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] row,
    input  sled_pkg::pos_flags_t                          flags,
    output sled_pkg::cand_t                               cand [sled_pkg::NUM_CAND]
);

    import sled_pkg::*;

    logic [PIXEL_BITS-1:0] win_a_reg [3];   // column c-2, rows r-2..r
    logic [PIXEL_BITS-1:0] win_b_reg [3];   // column c-1, rows r-2..r
    logic [PIXEL_BITS-1:0] grid [3][3];
    logic [2:0]            row_ok;
    logic [2:0]            col_ok;

    // Strict extremum test of grid[ky][kx] against its valid neighbours
    function automatic logic is_ext(input logic [PIXEL_BITS-1:0] g [3][3],
                                    input logic [2:0] rok, input logic [2:0] cok,
                                    input int ky, input int kx, input logic maxm);
        logic ok;
        ok = 1'b1;
        for (int y = 0; y < 3; y++) begin
            for (int x = 0; x < 3; x++) begin
                if ((y >= ky - 1) && (y <= ky + 1) && (x >= kx - 1) && (x <= kx + 1) &&
                    !((y == ky) && (x == kx)) && rok[y] && cok[x]) begin
                    if (maxm) begin
                        if (g[y][x] >= g[ky][kx]) ok = 1'b0;
                    end else begin
                        if (g[y][x] <= g[ky][kx]) ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

    // Assemble the 3x3 grid ending at the newest pixel
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            grid[k][0] = win_a_reg[k];
            grid[k][1] = win_b_reg[k];
        end
        grid[0][2] = above2;
        grid[1][2] = above1;
        grid[2][2] = pixel;
    end

    assign row_ok = {1'b1, flags.row_ge1, flags.row_ge2};
    assign col_ok = {1'b1, flags.col_ge1, flags.col_ge2};

    // Candidates in report order
    always_comb begin
        cand[0].vld        = flags.row_ge1 && flags.col_ge1 &&
                             is_ext(grid, row_ok, col_ok, 1, 1, find_maxima);
        cand[0].peak.col   = PEAK_COL_W'(col - 1'b1);
        cand[0].peak.row   = PEAK_ROW_W'(row - 1'b1);
        cand[0].peak.value = PEAK_VALUE_W'(grid[1][1]);

        cand[1].vld        = flags.row_ge1 && flags.last_col &&
                             is_ext(grid, row_ok, col_ok, 1, 2, find_maxima);
        cand[1].peak.col   = PEAK_COL_W'(col);
        cand[1].peak.row   = PEAK_ROW_W'(row - 1'b1);
        cand[1].peak.value = PEAK_VALUE_W'(grid[1][2]);

        cand[2].vld        = flags.last_row && flags.col_ge1 &&
                             is_ext(grid, row_ok, col_ok, 2, 1, find_maxima);
        cand[2].peak.col   = PEAK_COL_W'(col - 1'b1);
        cand[2].peak.row   = PEAK_ROW_W'(row);
        cand[2].peak.value = PEAK_VALUE_W'(grid[2][1]);

        cand[3].vld        = flags.last_row && flags.last_col &&
                             is_ext(grid, row_ok, col_ok, 2, 2, find_maxima);
        cand[3].peak.col   = PEAK_COL_W'(col);
        cand[3].peak.row   = PEAK_ROW_W'(row);
        cand[3].peak.value = PEAK_VALUE_W'(grid[2][2]);
    end

    // Window shift, one column per evaluated item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                win_a_reg[k] <= '0;
                win_b_reg[k] <= '0;
            end
        end else if (advance) begin
            for (int k = 0; k < 3; k++) begin
                win_a_reg[k] <= win_b_reg[k];
                win_b_reg[k] <= grid[k][2];
            end
        end
    end

endmodule

@@ hw/rtl/sled_out_queue.sv @@
// ----------------------------------------------------------------------------
// sled_out_queue
// Result register for the reports of one item; sends them one per cycle while
// m_tready is high, in candidate order, and marks the final one with tlast.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sled_out_queue (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  sled_pkg::cand_t                     cand [sled_pkg::NUM_CAND],
    output logic                                load_ready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sled_pkg::OUT_DATA_W-1:0]     m_tdata,   // peak_col, peak_row, peak_value
    output logic                                m_tlast    // last_of_run
);

    import sled_pkg::*;

    logic [NUM_CAND-1:0] vld_reg;
    logic [NUM_CAND-1:0] vld_next;
    peak_t               peak_reg [NUM_CAND];
    logic [CAND_IDX_W-1:0] sel;
    logic [NUM_CAND-1:0] rest;
    logic                m_fire;

    // Lowest pending entry goes out first
    always_comb begin
        sel = '0;
        for (int i = NUM_CAND - 1; i >= 0; i--) begin
            if (vld_reg[i]) sel = CAND_IDX_W'(i);
        end
        rest = vld_reg & ~(NUM_CAND'(1) << sel);
    end

    assign m_tvalid   = |vld_reg;
    assign m_tlast    = (rest == '0);
    assign m_tdata    = OUT_DATA_W'(peak_reg[sel]);
    assign m_fire     = m_tvalid && m_tready;
    assign load_ready = (vld_reg == '0) || (m_fire && m_tlast);

    // Pending mask
    always_comb begin
        vld_next = vld_reg;
        if (load) begin
            for (int i = 0; i < NUM_CAND; i++) vld_next[i] = cand[i].vld;
        end else if (m_fire) begin
            vld_next = rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < NUM_CAND; i++) peak_reg[i] <= cand[i].peak;
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the strict 3x3 local extremum detector. Pixel items
// are streamed in raster order in random bursts while the report side stalls
// on its own pattern; a built-in predictor of the detector computes the
// expected reports, which are compared field by field as they arrive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import sled_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE        = 8;          // idle cycles before a register write
    localparam int DRAIN_LIMIT   = 20000;
    localparam int TIMEOUT_NS    = 15_000_000;
    localparam int RANDOM_PIXELS = 250;
    localparam int PRINT_CAP     = 60;
    localparam int LINE_DEPTH    = MAX_WIDTH_DEF;

    // What the pixel feed does next
    typedef enum logic [1:0] {
        FEED_PIXEL,
        FEED_REG_WRITE,
        FEED_HOLD                              // wait until every report is in
    } feed_kind_e;

    typedef enum int {
        TEX_NOISE,                             // full-range random
        TEX_FLAT,                              // narrow range, many ties
        TEX_RAILS                              // mostly 0 and 255
    } texture_e;

    typedef struct {
        feed_kind_e              kind;
        logic [CFG_INDEX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0]   reg_value;
        logic [7:0]              pixel;
    } feed_entry_t;

    typedef struct packed {
        logic  last;
        peak_t peak;
    } report_t;

    // DUT ports
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;     // pixel
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;            // peak_col, peak_row, peak_value
    logic                   m_tlast;            // last_of_run
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Stimulus plan and expected reports
    feed_entry_t pixel_feed[$];
    report_t     pending_peaks[$];
    int          plan_w = IMAGE_WIDTH_RST;
    int          plan_h = IMAGE_HEIGHT_RST;
    int          random_pixels = 0;

    // Predictor state
    logic                  reg_find_max = FIND_MAXIMA_RST;
    logic [CFG_DATA_W-1:0] reg_width    = IMAGE_WIDTH_RST;
    logic [CFG_DATA_W-1:0] reg_height   = IMAGE_HEIGHT_RST;
    logic [7:0] line_one_up [LINE_DEPTH] = '{default: 8'h00};
    logic [7:0] line_two_up [LINE_DEPTH] = '{default: 8'h00};
    logic [7:0] win_cols [6] = '{default: 8'h00};
    int         col_pos = 0;
    int         row_pos = 0;
    logic [7:0] hood [3][3];
    bit         row_ok [3];
    bit         col_ok [3];

    // Driver and monitor bookkeeping
    int          quiet_cycles = 0;
    int          burst_left   = 0;
    int          gap_left     = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int          stall_tick   = 0;

    // Tallies
    int fail_count   = 0;
    int shown        = 0;
    int pixels_taken = 0;
    int reports_seen = 0;
    int reg_writes   = 0;
    int holds_done   = 0;
    int peaks_max    = 0;
    int peaks_min    = 0;

    strict_local_extremum_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Zero acts as one, anything above the limit as the limit
    function automatic int clamp_geom(input logic [CFG_DATA_W-1:0] v, input int hi);
        if (v == 0)
            return 1;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    // Strict comparison of hood[ky][kx] against its in-image neighbours
    function automatic bit is_strict_peak(input int ky, input int kx);
        int y;
        int x;
        for (y = ky - 1; y <= ky + 1; y++) begin
            if (y < 0 || y > 2)
                continue;
            if (!row_ok[y])
                continue;
            for (x = kx - 1; x <= kx + 1; x++) begin
                if (x < 0 || x > 2)
                    continue;
                if (!col_ok[x] || (y == ky && x == kx))
                    continue;
                if (reg_find_max) begin
                    if (hood[y][x] >= hood[ky][kx])
                        return 1'b0;
                end else begin
                    if (hood[y][x] <= hood[ky][kx])
                        return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic report_t make_report(input int col, input int row, input logic [7:0] v);
        report_t rep;
        rep.last       = 1'b0;
        rep.peak.col   = PEAK_COL_W'(col);
        rep.peak.row   = PEAK_ROW_W'(row);
        rep.peak.value = v;
        return rep;
    endfunction

    // Advance the detector by one pixel and queue the reports it completes
    task automatic predict_peaks(input logic [7:0] px);
        int         w;
        int         h;
        int         c;
        int         r;
        int         k;
        bit         at_last_col;
        bit         at_last_row;
        logic [7:0] up2;
        logic [7:0] up1;
        report_t    found[$];
        w = clamp_geom(reg_width, MAX_WIDTH_DEF);
        h = clamp_geom(reg_height, MAX_HEIGHT_DEF);
        c = col_pos;
        r = row_pos;
        at_last_col = (c >= w - 1);
        at_last_row = (r >= h - 1);

        // line stores shift down one row at this column
        up2 = line_two_up[c];
        up1 = line_one_up[c];
        line_two_up[c] = up1;
        line_one_up[c] = px;

        for (k = 0; k < 3; k++) begin
            hood[k][0] = win_cols[k];
            hood[k][1] = win_cols[3 + k];
        end
        hood[0][2] = up2;
        hood[1][2] = up1;
        hood[2][2] = px;
        row_ok[0] = (r >= 2);
        row_ok[1] = (r >= 1);
        row_ok[2] = 1'b1;
        col_ok[0] = (c >= 2);
        col_ok[1] = (c >= 1);
        col_ok[2] = 1'b1;

        // candidates in raster order of the reported pixel
        if (r >= 1) begin
            if (c >= 1 && is_strict_peak(1, 1))
                found = {found, make_report(c - 1, r - 1, hood[1][1])};
            if (at_last_col && is_strict_peak(1, 2))
                found = {found, make_report(c, r - 1, hood[1][2])};
        end
        if (at_last_row) begin
            if (c >= 1 && is_strict_peak(2, 1))
                found = {found, make_report(c - 1, r, hood[2][1])};
            if (at_last_col && is_strict_peak(2, 2))
                found = {found, make_report(c, r, hood[2][2])};
        end
        if (found.size() != 0)
            found[found.size() - 1].last = 1'b1;
        pending_peaks = {pending_peaks, found};
        if (reg_find_max)
            peaks_max += found.size();
        else
            peaks_min += found.size();

        for (k = 0; k < 3; k++) begin
            win_cols[k]     = win_cols[3 + k];
            win_cols[3 + k] = hood[k][2];
        end

        if (at_last_col) begin
            col_pos = 0;
            row_pos = at_last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus plan
    // ------------------------------------------------------------------------

    task automatic queue_pixel(input logic [7:0] p);
        feed_entry_t e;
        e = '{kind: FEED_PIXEL, reg_index: '0, reg_value: '0, pixel: p};
        pixel_feed = {pixel_feed, e};
    endtask

    task automatic queue_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
        feed_entry_t e;
        e = '{kind: FEED_REG_WRITE, reg_index: idx, reg_value: val, pixel: '0};
        pixel_feed = {pixel_feed, e};
        if (idx == REG_IMAGE_WIDTH)
            plan_w = clamp_geom(val, MAX_WIDTH_DEF);
        else if (idx == REG_IMAGE_HEIGHT)
            plan_h = clamp_geom(val, MAX_HEIGHT_DEF);
    endtask

    task automatic queue_hold();
        feed_entry_t e;
        e = '{kind: FEED_HOLD, reg_index: '0, reg_value: '0, pixel: '0};
        pixel_feed = {pixel_feed, e};
    endtask

    function automatic logic [7:0] random_pixel(input texture_e tex);
        case (tex)
            TEX_FLAT: return 8'($urandom_range(0, 3));
            TEX_RAILS: begin
                case ($urandom_range(0, 2))
                    0:       return 8'h00;
                    1:       return 8'hFF;
                    default: return 8'($urandom_range(0, 255));
                endcase
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Whole images at the planned geometry, with the odd mid-image hold
    task automatic queue_frames(input int frames, input texture_e tex, input bit counted);
        int n;
        for (n = 0; n < frames * plan_w * plan_h; n++) begin
            queue_pixel(random_pixel(tex));
            if ($urandom_range(0, 79) == 0)
                queue_hold();
        end
        if (counted)
            random_pixels += frames * plan_w * plan_h;
    endtask

    // Mostly small sizes, sometimes zero, now and then somewhat larger
    function automatic logic [CFG_DATA_W-1:0] pick_dim(input int top);
        case ($urandom_range(0, 9))
            0:       return '0;
            9:       return CFG_DATA_W'($urandom_range(top, 2 * top));
            default: return CFG_DATA_W'($urandom_range(1, top));
        endcase
    endfunction

    task automatic queue_directed();
        logic [7:0] corners [9] = '{8'd200, 8'd10, 8'd255,
                                    8'd10, 8'd128, 8'd10,
                                    8'd254, 8'd10, 8'd0};
        logic [7:0] first_rows [6] = '{8'd9, 8'd9, 8'd3, 8'd250, 8'd1, 8'd100};

        // 3x3 image in reset mode (maxima): three corner peaks and no others
        queue_reg_write(REG_IMAGE_WIDTH, 11'd3);
        queue_reg_write(REG_IMAGE_HEIGHT, 11'd3);
        foreach (corners[i])
            queue_pixel(corners[i]);

        // zero geometry acts as 1x1: every pixel is its own extremum
        queue_reg_write(REG_FIND_MAXIMA, 11'd0);
        queue_reg_write(REG_IMAGE_WIDTH, 11'd0);
        queue_reg_write(REG_IMAGE_HEIGHT, 11'd0);
        queue_pixel(8'd255);
        queue_pixel(8'd0);

        // mode switched and width narrowed part way through an image
        queue_reg_write(REG_FIND_MAXIMA, 11'd1);
        queue_reg_write(REG_IMAGE_WIDTH, 11'd4);
        queue_reg_write(REG_IMAGE_HEIGHT, 11'd3);
        foreach (first_rows[i])
            queue_pixel(first_rows[i]);
        queue_reg_write(REG_FIND_MAXIMA, 11'd0);
        queue_pixel(8'd2);
        queue_reg_write(REG_IMAGE_WIDTH, 11'd2);
        queue_pixel(8'd0);
        queue_pixel(8'd0);
        queue_pixel(8'd60);

        // height cut short part way through an image
        queue_reg_write(REG_IMAGE_HEIGHT, 11'd5);
        queue_pixel(8'd0);
        queue_pixel(8'd255);
        queue_pixel(8'd128);
        queue_pixel(8'd128);
        queue_reg_write(REG_IMAGE_HEIGHT, 11'd2);
        queue_pixel(8'd255);
        queue_pixel(8'd1);
    endtask

    task automatic queue_random_part();
        int n;
        int frames;
        int room;

        // out-of-range geometry acts as the limit; narrowed after part of a row,
        // so the row ends at the next pixel and the image finishes at 6x3
        queue_reg_write(REG_FIND_MAXIMA, 11'd1);
        queue_reg_write(REG_IMAGE_WIDTH, 11'd2047);
        queue_reg_write(REG_IMAGE_HEIGHT, 11'd2047);
        for (n = 0; n < 20; n++)
            queue_pixel(random_pixel(TEX_NOISE));
        queue_reg_write(REG_IMAGE_WIDTH, 11'd6);
        queue_reg_write(REG_IMAGE_HEIGHT, 11'd3);
        for (n = 0; n < 13; n++)
            queue_pixel(random_pixel(TEX_NOISE));

        // one column, height cut below the row already reached
        queue_reg_write(REG_FIND_MAXIMA, 11'd0);
        queue_reg_write(REG_IMAGE_WIDTH, 11'd1);
        queue_reg_write(REG_IMAGE_HEIGHT, 11'd2047);
        for (n = 0; n < 5; n++)
            queue_pixel(random_pixel(TEX_RAILS));
        queue_reg_write(REG_IMAGE_HEIGHT, 11'd4);
        queue_pixel(random_pixel(TEX_RAILS));

        // small images at random settings until the pixel budget is reached
        while (random_pixels < RANDOM_PIXELS) begin
            if ($urandom_range(0, 2) != 0)
                queue_reg_write(REG_FIND_MAXIMA, CFG_DATA_W'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) != 0)
                queue_reg_write(REG_IMAGE_WIDTH, pick_dim(12));
            if ($urandom_range(0, 2) != 0)
                queue_reg_write(REG_IMAGE_HEIGHT, pick_dim(6));
            room = RANDOM_PIXELS - random_pixels;
            if (plan_w * plan_h > room)
                queue_reg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(1));
            frames = (2 * plan_w * plan_h > room) ? 1 : int'($urandom_range(1, 2));
            queue_frames(frames, texture_e'($urandom_range(0, 2)), 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Pixel and register driver
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : feed_driver
        feed_entry_t next;
        logic        nxt_svalid;
        logic        nxt_cfgvalid;
        logic [7:0]  nxt_pixel;
        if (aresetn) begin
            nxt_svalid   = s_tvalid;
            nxt_cfgvalid = cfg_valid;
            nxt_pixel    = s_tdata;

            // retire what was taken at this edge
            if (s_tvalid && s_tready) begin
                predict_peaks(s_tdata);
                pixels_taken++;
                nxt_svalid = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FIND_MAXIMA:  reg_find_max = cfg_data[0];
                    REG_IMAGE_WIDTH:  reg_width    = cfg_data;
                    REG_IMAGE_HEIGHT: reg_height   = cfg_data;
                    default: ;
                endcase
                reg_writes++;
                nxt_cfgvalid = 1'b0;
            end

            // count cycles with nothing in flight
            if (s_tvalid || pending_peaks.size() != 0)
                quiet_cycles = 0;
            else if (quiet_cycles < SETTLE)
                quiet_cycles++;

            if (!nxt_svalid && !nxt_cfgvalid && pixel_feed.size() != 0) begin
                next = pixel_feed[0];
                case (next.kind)
                    FEED_PIXEL: begin
                        if (gap_left > 0) begin
                            gap_left--;
                        end else begin
                            void'(pixel_feed.pop_front());
                            nxt_svalid = 1'b1;
                            nxt_pixel  = next.pixel;
                            burst_left--;
                            if (burst_left <= 0) begin
                                burst_left = $urandom_range(1, 24);
                                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                            end
                        end
                    end
                    FEED_REG_WRITE: begin
                        if (quiet_cycles >= SETTLE) begin
                            void'(pixel_feed.pop_front());
                            cfg_index    <= next.reg_index;
                            cfg_data     <= next.reg_value;
                            nxt_cfgvalid = 1'b1;
                        end
                    end
                    default: begin
                        if (quiet_cycles >= SETTLE) begin
                            void'(pixel_feed.pop_front());
                            holds_done++;
                        end
                    end
                endcase
            end

            s_tvalid  <= nxt_svalid;
            s_tdata   <= nxt_pixel;
            cfg_valid <= nxt_cfgvalid;
        end
    end

    // ------------------------------------------------------------------------
    // Report monitor
    // ------------------------------------------------------------------------
    function automatic void check_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v) begin
            fail_count++;
            if (shown < PRINT_CAP) begin
                shown++;
                $display("%0d ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want_v, got_v);
            end
        end
    endfunction

    always @(posedge aclk) begin : peak_monitor
        report_t     want;
        peak_t       got;
        logic [15:0] pat;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = peak_t'(m_tdata[OUT_FIELDS_W-1:0]);
                reports_seen++;
                if (pending_peaks.size() == 0) begin
                    fail_count++;
                    if (shown < PRINT_CAP) begin
                        shown++;
                        $display("%0d ns: expected no report, actual col %0d row %0d value %0d",
                                 $time, got.col, got.row, got.value);
                    end
                end else begin
                    want = pending_peaks.pop_front();
                    check_field("peak_col",    want.peak.col,   got.col);
                    check_field("peak_row",    want.peak.row,   got.row);
                    check_field("peak_value",  want.peak.value, got.value);
                    check_field("last_of_run", want.last,       m_tlast);
                end
            end

            // rotate the stall pattern, periodically re-drawn at random
            stall_tick++;
            if (stall_tick % 32 == 0)
                pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            else
                pat = {stall_pattern[0], stall_pattern[15:1]};
            stall_pattern <= pat;
            m_tready      <= pat[0];
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing and end of run
    // ------------------------------------------------------------------------
    initial begin : run_control
        int k;
        queue_directed();
        queue_random_part();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (pixel_feed.size() != 0 || s_tvalid || cfg_valid)
            @(posedge aclk);
        for (k = 0; k < DRAIN_LIMIT && pending_peaks.size() != 0; k++)
            @(posedge aclk);
        repeat (2 * SETTLE) @(posedge aclk);

        if (pending_peaks.size() != 0) begin
            fail_count += pending_peaks.size();
            $display("%0d ns: %0d expected reports never arrived", $time, pending_peaks.size());
        end

        $display("Covered %0d pixels and %0d reports (%0d maxima, %0d minima),",
                 pixels_taken, reports_seen, peaks_max, peaks_min);
        $display("with %0d register writes and %0d full drains of the report side.",
                 reg_writes, holds_done);
        if (fail_count == 0) begin
            $display("strict_local_extremum_detector verification clean");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("strict_local_extremum_detector verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("%0d ns: run did not complete in time", $time);
        $display("strict_local_extremum_detector verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/sled_pkg.sv
hw/rtl/sled_line_store.sv
hw/rtl/sled_nms.sv
hw/rtl/sled_out_queue.sv
hw/rtl/strict_local_extremum_detector.sv
tb/sv/testbench.sv
